// ----- sv/lac_pkg.sv -----
// ----------------------------------------------------------------------------
// Layered access-right check: shared definitions
// Codes, sizes and the types that pass between the cells, the output buffer
// and the top level.
// ----------------------------------------------------------------------------
package lac_pkg;

   // Sizes of the rights vector and of the layer stack.
   localparam int NUM_RIGHTS = 16;
   localparam int MAX_LAYERS = 16;
   localparam int LAYER_W    = 4;
   localparam int COUNT_W    = 5;

   // Request kinds carried on req_tuser.
   localparam logic [1:0] KIND_BEGIN     = 2'd0;
   localparam logic [1:0] KIND_HANDLED   = 2'd1;
   localparam logic [1:0] KIND_GRANT     = 2'd2;
   localparam logic [1:0] KIND_NO_LAYERS = 2'd3;

   // Result kinds carried on rsp_tuser.
   localparam logic VK_SUMMARY = 1'b0;
   localparam logic VK_VERDICT = 1'b1;

   // Configuration register addresses (word index).
   localparam logic REG_NUM_RIGHTS = 1'b0;

   // Command broadcast to every cell for the request being accepted.
   typedef struct packed {
      logic                    load;
      logic                    mark;
      logic                    clear;
      logic [MAX_LAYERS-1:0]   layer_onehot;
   } cell_cmd_type;

   // One result on its way to the output.
   typedef struct packed {
      logic                    verdict_kind;
      logic                    allowed;
      logic [NUM_RIGHTS-1:0]   handled_rights;
   } rsp_type;

endpackage

// ----- sv/lac_cell.sv -----
// ----------------------------------------------------------------------------
// Layered access-right check: one right
// Holds the requested bit, the pending-layer mask and the handled bit of one
// access right, and passes the emptiness and request-present flags along.
// ----------------------------------------------------------------------------
module lac_cell
   import lac_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  logic          right_bit,
   input  logic          in_use,
   input  logic          empty_from,
   input  logic          req_from,
   output logic          empty_to,
   output logic          req_to,
   output logic          handled_next
);

   logic                  req_ff;
   logic                  req_in;
   logic [MAX_LAYERS-1:0] pending_ff;
   logic [MAX_LAYERS-1:0] pending_in;
   logic                  handled_ff;
   logic                  handled_in;
   logic                  active;

   // The right takes part only when it is requested and within the count.
   assign active = req_ff & in_use;

   // Next state of the right.
   always_comb begin
      req_in     = req_ff;
      pending_in = pending_ff;
      handled_in = handled_ff;
      if (cmd.load) begin
         req_in     = right_bit;
         pending_in = '0;
         handled_in = 1'b0;
      end else if (cmd.mark && active && right_bit) begin
         pending_in = pending_ff | cmd.layer_onehot;
         handled_in = 1'b1;
      end else if (cmd.clear && active && right_bit) begin
         pending_in = pending_ff & ~cmd.layer_onehot;
      end
   end

   // Chain outputs: the request is empty of pending layers only if every
   // active right has none left after this layer.
   assign empty_to     = empty_from & ~(active & (|pending_in));
   assign req_to       = req_from | req_ff;
   assign handled_next = handled_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff     <= 1'b0;
         pending_ff <= '0;
         handled_ff <= 1'b0;
      end else begin
         req_ff     <= req_in;
         pending_ff <= pending_in;
         handled_ff <= handled_in;
      end
   end

endmodule

// ----- sv/lac_skid.sv -----
// ----------------------------------------------------------------------------
// Layered access-right check: output buffer
// An output register backed by a skid register, so that a new request can be
// taken while a finished result is still waiting.
// ----------------------------------------------------------------------------
module lac_skid
   import lac_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;

   // Refill the output register from the skid first, else from the new result.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ----- sv/layered_access_right_check.sv -----
// ----------------------------------------------------------------------------
// Layered access-right check
// Tracks which policy layers still deny each requested right and reports the
// handled-rights summary and the rule verdicts.
// ----------------------------------------------------------------------------
// Each result is registered: output register, or skid then output when stalled.
// Throughput: one request per cycle while req_tready is high; all rights are
// updated at once by a row of sixteen cells, one per right.
// Up to two results are buffered; req_tready drops only when both are held.
// Reset (synchronous) clears all rights state and sets num_rights to 16.
module layered_access_right_check
   import lac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // access_bits[15:0], layer_index[19:16], zero
   input  logic [1:0]  req_tuser,   // kind[1:0]
   input  logic        req_tlast,
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // allowed[0], handled_rights[16:1], zero
   output logic        rsp_tuser,   // verdict_kind[0]
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [COUNT_W-1:0]    num_rights_ff;
   logic [COUNT_W-1:0]    num_rights_in;
   logic                  decided_ff;
   logic                  decided_in;
   logic                  accept;
   logic [NUM_RIGHTS-1:0] access_bits;
   logic [LAYER_W-1:0]    layer_index;
   logic [NUM_RIGHTS-1:0] in_use;
   logic [NUM_RIGHTS-1:0] handled_vec;
   logic [NUM_RIGHTS:0]   empty_chain;
   logic [NUM_RIGHTS:0]   req_chain;
   logic                  req_any;
   logic                  all_clear;
   cell_cmd_type          cmd;
   logic                  push;
   rsp_type               push_data;
   rsp_type               out_data;
   logic                  csr_write;

   assign access_bits = req_tdata[NUM_RIGHTS-1:0];
   assign layer_index = req_tdata[NUM_RIGHTS +: LAYER_W];
   assign accept      = req_tvalid & req_tready;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   always_comb begin
      num_rights_in = num_rights_ff;
      if (csr_write && csr_paddr[2] == REG_NUM_RIGHTS) begin
         num_rights_in = csr_pwdata[COUNT_W-1:0];
      end
   end
   assign csr_prdata = (csr_paddr[2] == REG_NUM_RIGHTS) ?
                       {{(32-COUNT_W){1'b0}}, num_rights_ff} : 32'd0;

   // Rights within the count; a count of sixteen or more covers all of them.
   always_comb begin
      for (int i = 0; i < NUM_RIGHTS; i++) begin
         in_use[i] = (COUNT_W'(i) < num_rights_ff);
      end
   end

   // Command for the cells.
   always_comb begin
      cmd.load  = accept && req_tuser == KIND_BEGIN;
      cmd.mark  = accept && req_tuser == KIND_HANDLED;
      cmd.clear = accept && req_tuser == KIND_GRANT && !decided_ff;
      for (int j = 0; j < MAX_LAYERS; j++) begin
         cmd.layer_onehot[j] = (layer_index == LAYER_W'(j));
      end
   end

   // Row of cells, one per right, with the flags rippling along the row.
   assign empty_chain[0] = 1'b1;
   assign req_chain[0]   = 1'b0;
   for (genvar g = 0; g < NUM_RIGHTS; g++) begin : g_cell
      lac_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .right_bit    (access_bits[g]),
         .in_use       (in_use[g]),
         .empty_from   (empty_chain[g]),
         .req_from     (req_chain[g]),
         .empty_to     (empty_chain[g+1]),
         .req_to       (req_chain[g+1]),
         .handled_next (handled_vec[g])
      );
   end
   assign req_any   = req_chain[NUM_RIGHTS];
   assign all_clear = empty_chain[NUM_RIGHTS];

   // Result and rule state for the accepted request.
   always_comb begin
      decided_in = decided_ff;
      push       = 1'b0;
      push_data  = '{verdict_kind: VK_VERDICT, allowed: 1'b0, handled_rights: '0};
      if (accept) begin
         case (req_tuser)
            KIND_BEGIN: begin
               decided_in = 1'b0;
            end
            KIND_HANDLED: begin
               push                 = req_tlast;
               push_data.verdict_kind = VK_SUMMARY;
               push_data.handled_rights = handled_vec;
            end
            KIND_NO_LAYERS: begin
               decided_in        = 1'b0;
               push              = 1'b1;
               push_data.allowed = ~req_any;
            end
            KIND_GRANT: begin
               if (decided_ff) begin
                  decided_in = ~req_tlast;
               end else if (all_clear) begin
                  // An empty request also lands here: no cell is active.
                  decided_in        = ~req_tlast;
                  push              = 1'b1;
                  push_data.allowed = 1'b1;
               end else if (req_tlast) begin
                  push = 1'b1;
               end
            end
            default: begin
               decided_in = decided_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rights_ff <= COUNT_W'(NUM_RIGHTS);
         decided_ff    <= 1'b0;
      end else begin
         num_rights_ff <= num_rights_in;
         decided_ff    <= decided_in;
      end
   end

   // Output buffer.
   lac_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {7'd0, out_data.handled_rights, out_data.allowed};
   assign rsp_tuser = out_data.verdict_kind;

endmodule

// ----- sv/lac_checker.sv -----
// ----------------------------------------------------------------------------
// Layered access-right check: port checker
// Watches the result channel for the hold, reset and result-encoding properties.
// ----------------------------------------------------------------------------
module lac_checker
   import lac_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A result waiting for the consumer is held unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A summary never claims a grant.
   a_summary_not_allowed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == VK_SUMMARY |-> !rsp_tdata[0])
      else $error("summary result with allowed set");

   // A verdict carries no handled rights, and the padding stays zero.
   a_verdict_no_rights: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == VK_VERDICT |-> rsp_tdata[16:1] == 16'd0 &&
      rsp_tdata[23:17] == 7'd0)
      else $error("verdict result with handled rights");

   // No result is presented straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind layered_access_right_check lac_checker u_lac_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
